// ===== rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types and constants: phases, result status codes, register indexes,
// register reset values and the transaction payload structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

	localparam int COUNT_WIDTH_DEF = 20;

	localparam int TRIG_W = 10;
	localparam int TIMEOUT_W = 20;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W = 2;
	localparam int HALF_W = 19;

	localparam logic [TRIG_W-1:0] TRIG_RESET = TRIG_W'(10);
	localparam logic [TIMEOUT_W-1:0] RISE_TIMEOUT_RESET = TIMEOUT_W'(20000);
	localparam logic [TIMEOUT_W-1:0] FALL_TIMEOUT_RESET = TIMEOUT_W'(50000);
	localparam logic [TIMEOUT_W-1:0] MAX_PULSE_RESET = TIMEOUT_W'(40438);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_RISE = 2'd2,
		PH_FALL = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NORISE = 2'd1,
		ST_NOFALL = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRIGGER_TICKS      = 2'd0,
		CFG_RISE_TIMEOUT_TICKS = 2'd1,
		CFG_FALL_TIMEOUT_TICKS = 2'd2,
		CFG_MAX_PULSE_TICKS    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic cmd;
		logic echo_level;
	} in_item_t;

	typedef struct packed {
		logic              trig_level;
		logic              done_res;
		status_t           status;
		logic [HALF_W-1:0] half_ticks;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// The result is registered at the edge that accepts its tick.
// Throughput: one tick per cycle while out_ready is high; the output register is
// refilled in the same cycle it is taken; the phase logic is a single comb pass.
// Reset: phase idle, tick counter and last echo level cleared, configuration
// registers at their defaults, output register empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger #(
	parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire uer_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output uer_pkg::out_item_t                  out_data,
	input  wire logic                           cfg_we,
	input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int LW = (COUNT_WIDTH > uer_pkg::TIMEOUT_W) ? COUNT_WIDTH : uer_pkg::TIMEOUT_W;
	localparam logic [LW-1:0] CNT_MAX = LW'({COUNT_WIDTH{1'b1}});

	logic [uer_pkg::TRIG_W-1:0]    trigger_q;
	logic [uer_pkg::TIMEOUT_W-1:0] rise_timeout_q;
	logic [uer_pkg::TIMEOUT_W-1:0] fall_timeout_q;
	logic [uer_pkg::TIMEOUT_W-1:0] max_pulse_q;

	uer_pkg::phase_t        phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d, tick_inc;
	logic                   last_echo_q;
	logic                   out_valid_q;
	uer_pkg::out_item_t     out_q, res;
	logic                   accept;

	logic [LW-1:0] trig_lim, rise_lim, fall_lim, max_ext, tick_ext, tick_inc_ext;

	function automatic logic [LW-1:0] limit_of(input logic [LW-1:0] v);
		logic [LW-1:0] r;
		r = v;
		if (r == '0) begin
			r = LW'(1);
		end
		if (r > CNT_MAX) begin
			r = CNT_MAX;
		end
		return r;
	endfunction

	assign trig_lim = limit_of(LW'(trigger_q));
	assign rise_lim = limit_of(LW'(rise_timeout_q));
	assign fall_lim = limit_of(LW'(fall_timeout_q));
	assign max_ext = LW'(max_pulse_q);
	assign tick_inc = tick_q + COUNT_WIDTH'(1);
	assign tick_ext = LW'(tick_q);
	assign tick_inc_ext = LW'(tick_inc);

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		res = '0;
		res.status = uer_pkg::ST_OK;
		unique case (phase_q)
			uer_pkg::PH_IDLE: begin
				if (in_data.cmd) begin
					res.trig_level = 1'b1;
					if (trig_lim == LW'(1)) begin
						phase_d = uer_pkg::PH_RISE;
						tick_d = '0;
					end else begin
						phase_d = uer_pkg::PH_TRIG;
						tick_d = COUNT_WIDTH'(1);
					end
				end
			end
			uer_pkg::PH_TRIG: begin
				res.trig_level = 1'b1;
				if (tick_inc_ext >= trig_lim) begin
					phase_d = uer_pkg::PH_RISE;
					tick_d = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			uer_pkg::PH_RISE: begin
				if (in_data.echo_level && !last_echo_q) begin
					phase_d = uer_pkg::PH_FALL;
					tick_d = COUNT_WIDTH'(1);
				end else if (tick_inc_ext >= rise_lim) begin
					res.done_res = 1'b1;
					res.status = uer_pkg::ST_NORISE;
					phase_d = uer_pkg::PH_IDLE;
					tick_d = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			uer_pkg::PH_FALL: begin
				if (!in_data.echo_level) begin
					res.done_res = 1'b1;
					if (tick_ext > max_ext) begin
						res.status = uer_pkg::ST_RANGE;
					end else begin
						res.status = uer_pkg::ST_OK;
						res.half_ticks = tick_ext[uer_pkg::HALF_W:1];
					end
					phase_d = uer_pkg::PH_IDLE;
					tick_d = '0;
				end else if (tick_ext >= fall_lim) begin
					res.done_res = 1'b1;
					res.status = uer_pkg::ST_NOFALL;
					phase_d = uer_pkg::PH_IDLE;
					tick_d = '0;
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				phase_d = uer_pkg::PH_IDLE;
				tick_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= uer_pkg::TRIG_RESET;
			rise_timeout_q <= uer_pkg::RISE_TIMEOUT_RESET;
			fall_timeout_q <= uer_pkg::FALL_TIMEOUT_RESET;
			max_pulse_q <= uer_pkg::MAX_PULSE_RESET;
		end else if (cfg_we) begin
			unique case (uer_pkg::cfg_idx_t'(cfg_index))
				uer_pkg::CFG_TRIGGER_TICKS: begin
					trigger_q <= cfg_wdata[uer_pkg::TRIG_W-1:0];
				end
				uer_pkg::CFG_RISE_TIMEOUT_TICKS: begin
					rise_timeout_q <= cfg_wdata[uer_pkg::TIMEOUT_W-1:0];
				end
				uer_pkg::CFG_FALL_TIMEOUT_TICKS: begin
					fall_timeout_q <= cfg_wdata[uer_pkg::TIMEOUT_W-1:0];
				end
				uer_pkg::CFG_MAX_PULSE_TICKS: begin
					max_pulse_q <= cfg_wdata[uer_pkg::TIMEOUT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_IDLE;
			tick_q <= '0;
			last_echo_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				tick_q <= tick_d;
				last_echo_q <= in_data.echo_level;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire
